// ===== hw/rtl/lkvc_pkg.sv =====
// lkvc_pkg: shared types and constants for the lru key-value cache
// holds the request, result, cell entry and cell control structs
// no dependencies
package lkvc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 31;
  localparam int VAL_W       = 31;
  localparam int CAP_W       = 5;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             cmp_en;
    logic             shift;
    logic [KEY_W-1:0] cmp_key;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/lkvc_cell.sv =====
// lkvc_cell: one slot of the recency-ordered entry chain
// compares its key against the broadcast key and loads its upstream neighbor on shift
// depends on lkvc_pkg
module lkvc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lkvc_pkg::cell_ctrl_t ctrl,
  input  lkvc_pkg::entry_t    prev,
  output lkvc_pkg::entry_t    entry,
  output logic                match
);
  import lkvc_pkg::*;

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key_r   <= prev.key;
      value_r <= prev.value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match_r <= valid_r && (key_r == ctrl.cmp_key);
    end
  end

  assign entry.valid = valid_r;
  assign entry.key   = key_r;
  assign entry.value = value_r;
  assign match       = match_r;

endmodule

// ===== hw/rtl/lru_key_value_cache_unit.sv =====
// lru_key_value_cache_unit: fully associative key-value cache with lru replacement
// built as a chain of lkvc_cell slots kept in recency order, slot 0 most recent
// depends on lkvc_pkg and lkvc_cell
//
// usage:
//   a request (get or put) is taken on in_req when start is high and busy is low.
//   busy is high in the compare step of each accepted request, so a new request
//   can be taken again only in the update step; this comes from the two steps of the cell
//   chain: every cell compares its key in the compare step, the chain shifts in the next.
//   each request gives exactly one result on out_res, marked by out_strobe for a
//   single cycle, registered at the end of the update step. the receiver cannot stall:
//   the result register is overwritten by the next request's result.
//   a hit or a new key moves to the head of the chain and the entries ahead of it
//   shift down by one; a put miss at capacity drops the last valid cell and
//   reports its key.
//   capacity is written over the apb-style port at byte address 0; the user must
//   do so only while idle (the block does not check); zero acts as 1, above ENTRIES as ENTRIES.
//   reset (rst_n low, synchronous) empties the cache and sets capacity to 16;
//   no clearing pass is needed.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lkvc_pkg::req_t              in_req,
  output logic                        out_strobe,
  output lkvc_pkg::res_t              out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkvc_pkg::APB_AW-1:0] paddr,
  input  logic [lkvc_pkg::APB_DW-1:0] pwdata,
  output logic [lkvc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import lkvc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  req_t             req_r;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             strobe_r;
  res_t             res_r, res_nxt;

  entry_t           cell_q [ENTRIES];
  entry_t           cell_prev [ENTRIES];
  cell_ctrl_t       cell_ctrl [ENTRIES];
  entry_t           head;
  logic [ENTRIES-1:0] match_vec, valid_vec, last_vec, shift_vec;

  logic             accept;
  logic             is_put;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [VAL_W-1:0] hit_value;
  logic [KEY_W-1:0] victim_key;
  logic [CMP_W-1:0] cap_ext, eff_cap;
  logic             full;
  logic             in_upd;
  logic             upd, evict, insert;
  logic [IDX_W-1:0] pos;
  logic             cfg_wr;

  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;
  assign in_upd = (state_r == S_UPD);
  assign is_put = (req_r.opcode == OP_PUT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  // configuration register
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // one-hot match selects, last valid cell found from its neighbor
  always_comb begin
    hit_idx    = '0;
    hit_value  = '0;
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_value = hit_value | cell_q[i].value;
      end
      if (last_vec[i]) begin
        victim_key = victim_key | cell_q[i].key;
      end
    end
  end

  assign hit = |match_vec;

  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full   = (CMP_W'(occ_r) >= eff_cap);
  assign upd    = in_upd && (hit || is_put);
  assign evict  = in_upd && is_put && !hit && full;
  assign insert = in_upd && is_put && !hit && !full;

  // last cell that takes part in the shift
  always_comb begin
    priority if (hit) begin
      pos = hit_idx;
    end else if (full) begin
      pos = IDX_W'(CNT_W'(occ_r - CNT_W'(1)));
    end else begin
      pos = IDX_W'(occ_r);
    end
  end

  assign head.valid = 1'b1;
  assign head.key   = req_r.key;
  assign head.value = is_put ? req_r.value : hit_value;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      assign shift_vec[g] = upd && (IDX_W'(g) <= pos);
      assign valid_vec[g] = cell_q[g].valid;

      if (g == 0) begin : g_head
        assign cell_prev[g] = head;
      end else begin : g_link
        assign cell_prev[g] = cell_q[g-1];
      end

      if (g == ENTRIES - 1) begin : g_tail
        assign last_vec[g] = cell_q[g].valid;
      end else begin : g_mid
        assign last_vec[g] = cell_q[g].valid && !cell_q[g+1].valid;
      end

      assign cell_ctrl[g].cmp_en  = (state_r == S_CMP);
      assign cell_ctrl[g].shift   = shift_vec[g];
      assign cell_ctrl[g].cmp_key = req_r.key;

      lkvc_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cell_ctrl[g]),
        .prev  (cell_prev[g]),
        .entry (cell_q[g]),
        .match (match_vec[g])
      );
    end
  endgenerate

  assign occ_nxt = insert ? CNT_W'(occ_r + CNT_W'(1)) : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_comb begin
    res_nxt.found       = hit;
    res_nxt.read_value  = (!is_put && hit) ? hit_value : '0;
    res_nxt.evicted     = evict;
    res_nxt.evicted_key = evict ? victim_key : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_upd) begin
      res_r <= res_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  // valid cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells not contiguous from the head");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy count disagrees with valid cells");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_upd |-> $onehot0(match_vec))
    else $error("key present in more than one cell");

  a_strobe_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_UPD))
    else $error("result strobe without an update cycle");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.evicted) |-> !out_res.found)
    else $error("eviction reported on a hit");

endmodule
